>>> hw/rtl/tsd_pkg.sv
// ----------------------------------------------------------------------------
// tsd_pkg
// Shared constants, codes and controller/datapath interface types for the
// topic subscription dispatch block.
// ----------------------------------------------------------------------------
package tsd_pkg;

  localparam int unsigned TOPICS_DEF      = 256;
  localparam int unsigned SUBSCRIBERS_DEF = 8;

  localparam int unsigned MAX_MATCH   = 8;
  localparam int unsigned MATCH_CNT_W = 4;
  localparam int unsigned MATCH_IDX_W = 3;

  localparam int unsigned OP_W      = 2;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned TOPIC_W   = 16;
  localparam int unsigned SUB_W     = 3;
  localparam int unsigned TAG_W     = 8;
  localparam int unsigned PAYLOAD_W = 32;
  localparam int unsigned GROUP_W   = 8;
  localparam int unsigned TDATA_W   = 64;

  // entry word: [16] free, [15:8] group, [7:0] handler tag
  localparam int unsigned ENTRY_W = 1 + GROUP_W + TAG_W;

  localparam logic [OP_W-1:0] OP_SUB   = 2'd0;
  localparam logic [OP_W-1:0] OP_UNSUB = 2'd1;
  localparam logic [OP_W-1:0] OP_PUB   = 2'd2;

  localparam logic [STATUS_W-1:0] ST_ACCEPT  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_REJECT  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_DELIVER = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOSUB   = 2'd3;

  typedef struct packed {
    logic                capture;
    logic                clr_wr;
    logic                rd_entry;
    logic                wr_sub;
    logic                wr_free;
    logic                scan_start;
    logic                scan_step;
    logic                load_res;
    logic [STATUS_W-1:0] res_status;
    logic                emit_step;
  } cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            range_ok;
    logic            idx_ok;
    logic            entry_free;
    logic            scan_last;
    logic            mcnt_zero;
    logic            emit_last;
    logic            out_free;
    logic            clr_last;
  } sts_t;

endpackage

>>> hw/rtl/tsd_ram.sv
// ----------------------------------------------------------------------------
// tsd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tsd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AW-1:0]    wr_addr_i,
  input  logic [WIDTH-1:0] wr_data_i,
  input  logic             rd_en_i,
  input  logic [AW-1:0]    rd_addr_i,
  output logic [WIDTH-1:0] rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

>>> hw/rtl/tsd_datapath.sv
// ----------------------------------------------------------------------------
// tsd_datapath
// Item capture, entry table, subscriber scan, match buffer and result register.
// ----------------------------------------------------------------------------
module tsd_datapath #(
  parameter int unsigned TOPICS      = tsd_pkg::TOPICS_DEF,
  parameter int unsigned SUBSCRIBERS = tsd_pkg::SUBSCRIBERS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  tsd_pkg::cmd_t                  cmd_i,
  output tsd_pkg::sts_t                  sts_o,
  input  logic [tsd_pkg::OP_W-1:0]       in_op_i,
  input  logic [tsd_pkg::TOPIC_W-1:0]    in_topic_i,
  input  logic [tsd_pkg::SUB_W-1:0]      in_sub_i,
  input  logic [tsd_pkg::TAG_W-1:0]      in_tag_i,
  input  logic [tsd_pkg::PAYLOAD_W-1:0]  in_payload_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [tsd_pkg::STATUS_W-1:0]   out_status_o,
  output logic [tsd_pkg::SUB_W-1:0]      out_target_o,
  output logic [tsd_pkg::TAG_W-1:0]      out_handler_o,
  output logic [tsd_pkg::TOPIC_W-1:0]    out_topic_o,
  output logic [tsd_pkg::PAYLOAD_W-1:0]  out_payload_o,
  output logic                           out_last_o
);

  localparam int unsigned NE = TOPICS * SUBSCRIBERS;
  localparam int unsigned AW = (NE > 1) ? $clog2(NE) : 1;
  localparam int unsigned CW = (SUBSCRIBERS > 1) ? $clog2(SUBSCRIBERS) : 1;
  localparam int unsigned BW = 15;

  // captured item
  logic [tsd_pkg::OP_W-1:0]      op_q;
  logic [tsd_pkg::TOPIC_W-1:0]   topic_q;
  logic [tsd_pkg::SUB_W-1:0]     sub_q;
  logic [tsd_pkg::TAG_W-1:0]     tag_q;
  logic [tsd_pkg::PAYLOAD_W-1:0] payload_q;
  logic [AW-1:0]                 base_q;
  logic [BW-1:0]                 base_full;
  logic [tsd_pkg::GROUP_W-1:0]   grp;

  // scan / match / clear state
  logic [CW-1:0]                     cnt_q, cnt_d;
  logic [tsd_pkg::MATCH_CNT_W-1:0]   mcnt_q, mcnt_d;
  logic [tsd_pkg::MATCH_IDX_W-1:0]   emit_q, emit_d;
  logic [AW-1:0]                     clr_q, clr_d;
  logic [tsd_pkg::SUB_W-1:0]         mt_sub_q [tsd_pkg::MAX_MATCH];
  logic [tsd_pkg::TAG_W-1:0]         mt_tag_q [tsd_pkg::MAX_MATCH];
  logic [6:0]                        cnt_ext;
  logic                              hit;
  logic                              rec;

  // table access
  logic [AW-1:0]                 ent_addr;
  logic                          wr_en;
  logic [AW-1:0]                 wr_addr;
  logic [tsd_pkg::ENTRY_W-1:0]   wr_data;
  logic                          rd_en;
  logic [AW-1:0]                 rd_addr;
  logic [tsd_pkg::ENTRY_W-1:0]   rd_data;

  // result register
  logic                          out_valid_q, out_valid_d;
  logic [tsd_pkg::STATUS_W-1:0]  out_status_q;
  logic [tsd_pkg::SUB_W-1:0]     out_target_q;
  logic [tsd_pkg::TAG_W-1:0]     out_handler_q;
  logic [tsd_pkg::TOPIC_W-1:0]   out_topic_q;
  logic [tsd_pkg::PAYLOAD_W-1:0] out_payload_q;
  logic                          out_last_q;
  logic                          emit_last;

  assign base_full = BW'(in_topic_i[7:0]) * BW'(SUBSCRIBERS);
  assign grp       = topic_q[15:8];
  assign ent_addr  = base_q + AW'(sub_q);
  assign cnt_ext   = 7'(cnt_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q      <= in_op_i;
      topic_q   <= in_topic_i;
      sub_q     <= in_sub_i;
      tag_q     <= in_tag_i;
      payload_q <= in_payload_i;
      base_q    <= AW'(base_full);
    end
  end

  assign wr_en   = cmd_i.clr_wr | cmd_i.wr_sub | cmd_i.wr_free;
  assign wr_addr = cmd_i.clr_wr ? clr_q : ent_addr;
  assign wr_data = cmd_i.wr_sub ? {1'b0, grp, tag_q} : {1'b1, grp, tsd_pkg::TAG_W'(0)};

  assign rd_en   = cmd_i.rd_entry | cmd_i.scan_start | (cmd_i.scan_step & ~sts_o.scan_last);
  always_comb begin
    rd_addr = ent_addr;
    if (cmd_i.scan_start) begin
      rd_addr = base_q;
    end else if (cmd_i.scan_step) begin
      rd_addr = base_q + AW'(cnt_q) + AW'(1);
    end
  end

  tsd_ram #(
    .WIDTH (tsd_pkg::ENTRY_W),
    .DEPTH (NE)
  ) u_table (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  assign hit = ~rd_data[16] & ((grp == '0) | (rd_data[15:8] == grp));
  assign rec = cmd_i.scan_step & hit & (mcnt_q < tsd_pkg::MATCH_CNT_W'(tsd_pkg::MAX_MATCH));

  always_comb begin
    cnt_d  = cnt_q;
    mcnt_d = mcnt_q;
    emit_d = emit_q;
    clr_d  = clr_q;
    if (cmd_i.scan_start) begin
      cnt_d  = '0;
      mcnt_d = '0;
      emit_d = '0;
    end else if (cmd_i.scan_step) begin
      cnt_d = cnt_q + CW'(1);
    end
    if (rec) begin
      mcnt_d = mcnt_q + tsd_pkg::MATCH_CNT_W'(1);
    end
    if (cmd_i.emit_step) begin
      emit_d = emit_q + tsd_pkg::MATCH_IDX_W'(1);
    end
    if (cmd_i.clr_wr) begin
      clr_d = clr_q + AW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      mcnt_q <= '0;
      emit_q <= '0;
      clr_q  <= '0;
    end else begin
      cnt_q  <= cnt_d;
      mcnt_q <= mcnt_d;
      emit_q <= emit_d;
      clr_q  <= clr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rec) begin
      mt_sub_q[mcnt_q[tsd_pkg::MATCH_IDX_W-1:0]] <= cnt_ext[tsd_pkg::SUB_W-1:0];
      mt_tag_q[mcnt_q[tsd_pkg::MATCH_IDX_W-1:0]] <= rd_data[7:0];
    end
  end

  assign emit_last = ({1'b0, emit_q} == (mcnt_q - tsd_pkg::MATCH_CNT_W'(1)));

  // result register
  assign out_valid_d = cmd_i.load_res | (out_valid_q & ~out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_res) begin
      out_status_q <= cmd_i.res_status;
      case (cmd_i.res_status)
        tsd_pkg::ST_DELIVER: begin
          out_target_q  <= mt_sub_q[emit_q];
          out_handler_q <= mt_tag_q[emit_q];
          out_topic_q   <= topic_q;
          out_payload_q <= payload_q;
          out_last_q    <= emit_last;
        end
        tsd_pkg::ST_NOSUB: begin
          out_target_q  <= '0;
          out_handler_q <= '0;
          out_topic_q   <= topic_q;
          out_payload_q <= payload_q;
          out_last_q    <= 1'b1;
        end
        default: begin
          out_target_q  <= '0;
          out_handler_q <= '0;
          out_topic_q   <= '0;
          out_payload_q <= '0;
          out_last_q    <= 1'b1;
        end
      endcase
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_status_o  = out_status_q;
  assign out_target_o  = out_target_q;
  assign out_handler_o = out_handler_q;
  assign out_topic_o   = out_topic_q;
  assign out_payload_o = out_payload_q;
  assign out_last_o    = out_last_q;

  always_comb begin
    sts_o            = '0;
    sts_o.op         = op_q;
    sts_o.idx_ok     = ({1'b0, topic_q[7:0]} < 9'(TOPICS));
    sts_o.range_ok   = sts_o.idx_ok & ({4'b0, sub_q} < 7'(SUBSCRIBERS));
    sts_o.entry_free = rd_data[16];
    sts_o.scan_last  = (cnt_q == CW'(SUBSCRIBERS - 1));
    sts_o.mcnt_zero  = (mcnt_q == '0);
    sts_o.emit_last  = emit_last;
    sts_o.out_free   = ~out_valid_q | out_ready_i;
    sts_o.clr_last   = (clr_q == AW'(NE - 1));
  end

`ifndef SYNTHESIS
  a_mcnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mcnt_q <= tsd_pkg::MATCH_CNT_W'(tsd_pkg::MAX_MATCH))
    else $error("match count overflow");

  a_emit_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit_step |-> ({1'b0, emit_q} < mcnt_q))
    else $error("emit past recorded matches");

  a_sub_free_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.wr_sub |-> rd_data[16])
    else $error("subscribe overwrote a taken entry");
`endif

endmodule

>>> hw/rtl/tsd_ctrl.sv
// ----------------------------------------------------------------------------
// tsd_ctrl
// Sequencer: table clear after reset, decode, subscribe check, scan, emit.
// ----------------------------------------------------------------------------
module tsd_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  tsd_pkg::sts_t sts_i,
  output tsd_pkg::cmd_t cmd_o
);

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_DEC  = 3'd2;
  localparam logic [2:0] S_CHK  = 3'd3;
  localparam logic [2:0] S_SCAN = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;
  localparam logic [2:0] S_RESP = 3'd6;
  localparam logic [2:0] S_EMIT = 3'd7;

  logic [2:0]                   state_q, state_d;
  logic [tsd_pkg::STATUS_W-1:0] res_q, res_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    res_d   = res_q;
    cmd_o   = '0;
    case (state_q)
      S_CLR: begin
        cmd_o.clr_wr = 1'b1;
        if (sts_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_DEC;
        end
      end
      S_DEC: begin
        state_d = S_RESP;
        res_d   = tsd_pkg::ST_REJECT;
        case (sts_i.op)
          tsd_pkg::OP_SUB: begin
            if (sts_i.range_ok) begin
              cmd_o.rd_entry = 1'b1;
              state_d        = S_CHK;
            end
          end
          tsd_pkg::OP_UNSUB: begin
            if (sts_i.range_ok) begin
              cmd_o.wr_free = 1'b1;
              res_d         = tsd_pkg::ST_ACCEPT;
            end
          end
          tsd_pkg::OP_PUB: begin
            if (sts_i.idx_ok) begin
              cmd_o.scan_start = 1'b1;
              state_d          = S_SCAN;
            end else begin
              res_d = tsd_pkg::ST_NOSUB;
            end
          end
          default: begin
            res_d = tsd_pkg::ST_REJECT;
          end
        endcase
      end
      S_CHK: begin
        state_d = S_RESP;
        if (sts_i.entry_free) begin
          cmd_o.wr_sub = 1'b1;
          res_d        = tsd_pkg::ST_ACCEPT;
        end else begin
          res_d = tsd_pkg::ST_REJECT;
        end
      end
      S_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (sts_i.scan_last) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (sts_i.mcnt_zero) begin
          res_d   = tsd_pkg::ST_NOSUB;
          state_d = S_RESP;
        end else begin
          state_d = S_EMIT;
        end
      end
      S_RESP: begin
        cmd_o.res_status = res_q;
        if (sts_i.out_free) begin
          cmd_o.load_res = 1'b1;
          state_d        = S_IDLE;
        end
      end
      S_EMIT: begin
        cmd_o.res_status = tsd_pkg::ST_DELIVER;
        if (sts_i.out_free) begin
          cmd_o.load_res  = 1'b1;
          cmd_o.emit_step = 1'b1;
          if (sts_i.emit_last) begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
      res_q   <= tsd_pkg::ST_ACCEPT;
    end else begin
      state_q <= state_d;
      res_q   <= res_d;
    end
  end

`ifndef SYNTHESIS
  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_res |-> sts_i.out_free)
    else $error("result loaded over an untaken word");

  a_sub_then_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.wr_sub |=> (state_q == S_RESP) && (res_q == tsd_pkg::ST_ACCEPT))
    else $error("subscribe write without accept result");

  a_emit_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT) |-> !sts_i.mcnt_zero)
    else $error("emit with no recorded match");
`endif

endmodule

>>> hw/rtl/topic_subscription_dispatch.sv
// ----------------------------------------------------------------------------
// topic_subscription_dispatch
// Publish/subscribe dispatch table: subscribe, unsubscribe, publish fan-out.
// ----------------------------------------------------------------------------
// Channel  Dir  tuser      tlast  tdata (low bit up)
// s_axis   in   operation  -      topic, subscriber, handler_tag, payload
// m_axis   out  status     last   target, target_handler, topic_out, payload_out
//
// After reset the table is cleared one entry a cycle, all TOPICS*SUBSCRIBERS
// entries (2048 by default), with s_axis_tready low.
// Subscribe reads the entry, then writes it if free before the result loads;
// unsubscribe writes the entry free, and rejects go straight to the result.
// Publish reads one entry a cycle, then gives one delivery a cycle while
// m_axis is ready; an out-of-range topic index answers with no-subscriber.
// The next item is accepted only once the last result word is loaded.
// A stalled m_axis holds the controller; the last result word waits in the
// output register while the next word is accepted.
// ----------------------------------------------------------------------------
module topic_subscription_dispatch #(
  parameter int unsigned TOPICS      = tsd_pkg::TOPICS_DEF,
  parameter int unsigned SUBSCRIBERS = tsd_pkg::SUBSCRIBERS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // [15:0] topic, [18:16] subscriber, [26:19] handler_tag, [58:27] payload
  input  logic [tsd_pkg::TDATA_W-1:0]   s_axis_tdata,
  // [1:0] operation
  input  logic [tsd_pkg::OP_W-1:0]      s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [2:0] target, [10:3] target_handler, [26:11] topic_out, [58:27] payload_out
  output logic [tsd_pkg::TDATA_W-1:0]   m_axis_tdata,
  // [1:0] status
  output logic [tsd_pkg::STATUS_W-1:0]  m_axis_tuser,
  output logic                          m_axis_tlast
);

  tsd_pkg::cmd_t cmd;
  tsd_pkg::sts_t sts;

  logic [tsd_pkg::SUB_W-1:0]     out_target;
  logic [tsd_pkg::TAG_W-1:0]     out_handler;
  logic [tsd_pkg::TOPIC_W-1:0]   out_topic;
  logic [tsd_pkg::PAYLOAD_W-1:0] out_payload;

  tsd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  tsd_datapath #(
    .TOPICS      (TOPICS),
    .SUBSCRIBERS (SUBSCRIBERS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .in_op_i       (s_axis_tuser),
    .in_topic_i    (s_axis_tdata[15:0]),
    .in_sub_i      (s_axis_tdata[18:16]),
    .in_tag_i      (s_axis_tdata[26:19]),
    .in_payload_i  (s_axis_tdata[58:27]),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_status_o  (m_axis_tuser),
    .out_target_o  (out_target),
    .out_handler_o (out_handler),
    .out_topic_o   (out_topic),
    .out_payload_o (out_payload),
    .out_last_o    (m_axis_tlast)
  );

  assign m_axis_tdata = {5'b0, out_payload, out_topic, out_handler, out_target};

endmodule
